// ===== design/ftcc_pkg.sv =====
// Package for the frame timer calendar clock: codes, widths, reset values and helpers.
package ftcc_pkg;

	localparam int unsigned OP_W        = 3;
	localparam int unsigned PORT_W      = 3;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned YEAR_W      = 16;
	localparam int unsigned DAY_W       = 9;
	localparam int unsigned SEC_W       = 17;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 17;
	localparam int unsigned FRAME_MOD_W = 6;

	// Operation codes
	localparam logic [OP_W-1:0] OP_READ  = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
	localparam logic [OP_W-1:0] OP_FRAME = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	// Read ports
	localparam logic [PORT_W-1:0] PORT_DATE   = 3'd0;
	localparam logic [PORT_W-1:0] PORT_TIME   = 3'd1;
	localparam logic [PORT_W-1:0] PORT_FRAMES = 3'd2;
	localparam logic [PORT_W-1:0] PORT_CYCLES = 3'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_YEAR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_DAY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_SECONDS = 2'd2;

	localparam logic [YEAR_W-1:0] RESET_YEAR    = 16'd2024;
	localparam logic [DAY_W-1:0]  RESET_DAY     = 9'd0;
	localparam logic [SEC_W-1:0]  RESET_SECONDS = 17'd0;

	localparam logic [FRAME_MOD_W-1:0] FRAMES_PER_SECOND_M1 = 6'd59;
	localparam logic [SEC_W:0]         SECONDS_PER_DAY      = 18'd86400;
	localparam logic [DAY_W:0]         DAYS_LEAP_YEAR       = 10'd366;
	localparam logic [DAY_W:0]         DAYS_COMMON_YEAR     = 10'd365;

	// y divisible by 25 iff y * inverse(25) mod 2^16 <= floor(0xFFFF / 25)
	localparam logic [YEAR_W-1:0] INV25_MOD_2_16 = 16'd23593;
	localparam logic [YEAR_W-1:0] DIV25_LIMIT    = 16'd2621;

	typedef struct packed {
		logic tick;
		logic frame;
		logic clear;
	} ctl_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// Gregorian: divisible by 4 and not by 100, or by 400.
	// With 4 | y: 100 | y iff 25 | y, and 400 | y iff 16 | y and 25 | y.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [YEAR_W-1:0] prod;
		logic              div25;
		prod  = y * INV25_MOD_2_16;
		div25 = (prod <= DIV25_LIMIT);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

endpackage

// ===== design/ftcc_if.sv =====
// Channel interfaces: request, response and configuration write.
interface ftcc_req_if;
	logic                        valid;
	logic                        ready;
	logic [ftcc_pkg::OP_W-1:0]   op;
	logic [ftcc_pkg::PORT_W-1:0] port;

	modport source (output valid, output op, output port, input ready);
	modport sink   (input valid, input op, input port, output ready);
endinterface

interface ftcc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ftcc_pkg::DATA_W-1:0] read_data;
	logic                        ok;

	modport source (output valid, output read_data, output ok, input ready);
	modport sink   (input valid, input read_data, input ok, output ready);
endinterface

interface ftcc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ftcc_pkg::CFG_IDX_W-1:0]  index;
	logic [ftcc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/ftcc_counters.sv =====
// Cycle and frame counters with a frame-within-second counter for the seconds step.
module ftcc_counters (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ftcc_pkg::ctl_t              ctl,
	output logic [ftcc_pkg::DATA_W-1:0] cycle_count,
	output logic [ftcc_pkg::DATA_W-1:0] frame_count,
	output logic                        sec_step
);

	logic [ftcc_pkg::DATA_W-1:0]      cycle_q;
	logic [ftcc_pkg::DATA_W-1:0]      frame_q;
	logic [ftcc_pkg::FRAME_MOD_W-1:0] frame_mod_q;
	logic [ftcc_pkg::FRAME_MOD_W-1:0] frame_mod_next;

	// Tracks frame_count mod 60; the 32-bit wrap lands on zero, which is a multiple.
	always_comb begin
		if (frame_q == {ftcc_pkg::DATA_W{1'b1}}) begin
			frame_mod_next = '0;
		end else if (frame_mod_q == ftcc_pkg::FRAMES_PER_SECOND_M1) begin
			frame_mod_next = '0;
		end else begin
			frame_mod_next = frame_mod_q + 1'b1;
		end
	end

	assign sec_step = ctl.frame && (frame_mod_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q     <= '0;
			frame_q     <= '0;
			frame_mod_q <= '0;
		end else if (ctl.clear) begin
			cycle_q     <= '0;
			frame_q     <= '0;
			frame_mod_q <= '0;
		end else if (ctl.frame) begin
			cycle_q     <= '0;
			frame_q     <= frame_q + 1'b1;
			frame_mod_q <= frame_mod_next;
		end else if (ctl.tick) begin
			cycle_q <= cycle_q + 1'b1;
		end
	end

	assign cycle_count = cycle_q;
	assign frame_count = frame_q;

endmodule

// ===== design/ftcc_calendar.sv =====
// Seconds of day, day of year and year, with configuration load.
module ftcc_calendar (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        frame,
	input  logic                        sec_step,
	input  ftcc_pkg::cfg_wr_t           cfg_wr,
	output logic [ftcc_pkg::SEC_W-1:0]  seconds_of_day,
	output logic [ftcc_pkg::YEAR_W-1:0] year_value,
	output logic [ftcc_pkg::DAY_W-1:0]  day_of_year
);

	logic [ftcc_pkg::SEC_W-1:0]  sec_q;
	logic [ftcc_pkg::YEAR_W-1:0] year_q;
	logic [ftcc_pkg::DAY_W-1:0]  day_q;

	logic [ftcc_pkg::SEC_W:0]    sec_sum;
	logic [ftcc_pkg::DAY_W:0]    day_inc;
	logic [ftcc_pkg::DAY_W:0]    year_len;
	logic                        day_wrap;
	logic                        year_wrap;

	// Seconds may be loaded above a day's length; the sum needs one extra bit.
	assign sec_sum   = {1'b0, sec_q} + {{ftcc_pkg::SEC_W{1'b0}}, sec_step};
	assign day_wrap  = (sec_sum >= ftcc_pkg::SECONDS_PER_DAY);
	assign day_inc   = {1'b0, day_q} + 1'b1;
	assign year_len  = ftcc_pkg::is_leap(year_q) ? ftcc_pkg::DAYS_LEAP_YEAR
	                                             : ftcc_pkg::DAYS_COMMON_YEAR;
	assign year_wrap = (day_inc >= year_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= ftcc_pkg::RESET_SECONDS;
			year_q <= ftcc_pkg::RESET_YEAR;
			day_q  <= ftcc_pkg::RESET_DAY;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				ftcc_pkg::REG_START_YEAR: begin
					year_q <= cfg_wr.data[ftcc_pkg::YEAR_W-1:0];
				end
				ftcc_pkg::REG_START_DAY: begin
					day_q <= cfg_wr.data[ftcc_pkg::DAY_W-1:0];
				end
				ftcc_pkg::REG_START_SECONDS: begin
					sec_q <= cfg_wr.data[ftcc_pkg::SEC_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (frame) begin
			if (day_wrap) begin
				sec_q <= '0;
				if (year_wrap) begin
					year_q <= year_q + 1'b1;
					day_q  <= '0;
				end else begin
					day_q <= day_inc[ftcc_pkg::DAY_W-1:0];
				end
			end else begin
				sec_q <= sec_sum[ftcc_pkg::SEC_W-1:0];
			end
		end
	end

	assign seconds_of_day = sec_q;
	assign year_value     = year_q;
	assign day_of_year    = day_q;

endmodule

// ===== design/frame_timer_calendar_clock_core.sv =====
// Top level of the frame timer calendar clock: input stage, state update, response register.
//
// Channel  Role    Payload                    Transfer when
// req      sink    op[2:0], port[2:0]         req.valid && req.ready
// rsp      source  read_data[31:0], ok        rsp.valid && rsp.ready
// cfg      sink    index[1:0], data[16:0]     cfg.valid && cfg.ready
//
// One request per clock unless a stalled response holds the input stage. A request is
// registered, then when it fires it updates the counters and calendar and, for reads and
// writes, loads the response register that drives the response. cfg is always ready and
// loads the calendar state directly. Reset brings the date to year 2024, day 0, second 0.
// A stalled response holds the stage behind it only when that stage holds a read or write.
module frame_timer_calendar_clock_core (
	input logic       clk,
	input logic       arst_n,
	ftcc_req_if.sink  req,
	ftcc_rsp_if.source rsp,
	ftcc_cfg_if.sink  cfg
);

	logic                        valid_s1;
	logic [ftcc_pkg::OP_W-1:0]   op_s1;
	logic [ftcc_pkg::PORT_W-1:0] port_s1;

	logic                        rsp_valid_q;
	logic [ftcc_pkg::DATA_W-1:0] read_data_q;
	logic                        ok_q;

	logic                        has_rsp_s1;
	logic                        rsp_free;
	logic                        fire_s1;

	ftcc_pkg::ctl_t              ctl;
	ftcc_pkg::cfg_wr_t           cfg_wr;

	logic [ftcc_pkg::DATA_W-1:0] cycle_count;
	logic [ftcc_pkg::DATA_W-1:0] frame_count;
	logic                        sec_step;
	logic [ftcc_pkg::SEC_W-1:0]  seconds_of_day;
	logic [ftcc_pkg::YEAR_W-1:0] year_value;
	logic [ftcc_pkg::DAY_W-1:0]  day_of_year;

	logic [ftcc_pkg::DATA_W-1:0] rd_data;
	logic                        rd_ok;

	assign has_rsp_s1 = (op_s1 == ftcc_pkg::OP_READ) || (op_s1 == ftcc_pkg::OP_WRITE);
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign fire_s1    = valid_s1 && (!has_rsp_s1 || rsp_free);
	assign req.ready  = !valid_s1 || fire_s1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1   <= req.op;
			port_s1 <= req.port;
		end
	end

	always_comb begin
		ctl.tick  = fire_s1 && (op_s1 == ftcc_pkg::OP_TICK);
		ctl.frame = fire_s1 && (op_s1 == ftcc_pkg::OP_FRAME);
		ctl.clear = fire_s1 && (op_s1 == ftcc_pkg::OP_CLEAR);
	end

	always_comb begin
		cfg_wr.we    = cfg.valid;
		cfg_wr.index = cfg.index;
		cfg_wr.data  = cfg.data;
	end

	ftcc_counters u_counters (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cycle_count (cycle_count),
		.frame_count (frame_count),
		.sec_step    (sec_step)
	);

	ftcc_calendar u_calendar (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame          (ctl.frame),
		.sec_step       (sec_step),
		.cfg_wr         (cfg_wr),
		.seconds_of_day (seconds_of_day),
		.year_value     (year_value),
		.day_of_year    (day_of_year)
	);

	// Writes and invalid ports are refused with zero data.
	always_comb begin
		rd_data = '0;
		rd_ok   = 1'b0;
		if (op_s1 == ftcc_pkg::OP_READ) begin
			rd_ok = 1'b1;
			case (port_s1)
				ftcc_pkg::PORT_DATE: begin
					rd_data = {year_value, {(ftcc_pkg::DATA_W - ftcc_pkg::YEAR_W
					          - ftcc_pkg::DAY_W){1'b0}}, day_of_year};
				end
				ftcc_pkg::PORT_TIME: begin
					rd_data = {{(ftcc_pkg::DATA_W - ftcc_pkg::SEC_W){1'b0}}, seconds_of_day};
				end
				ftcc_pkg::PORT_FRAMES: begin
					rd_data = frame_count;
				end
				ftcc_pkg::PORT_CYCLES: begin
					rd_data = cycle_count;
				end
				default: begin
					rd_ok = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1 && has_rsp_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_rsp_s1) begin
			read_data_q <= rd_data;
			ok_q        <= rd_ok;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.ok        = ok_q;

endmodule
